// File: design/bae_pkg.sv
// shared types and constants of the binary arithmetic encoder
`default_nettype none

package bae_pkg;

    localparam int WORD_BITS        = 32;
    localparam int BYTE_BITS        = 8;
    localparam int TREE_DEPTH       = 256;
    localparam int NODE_BITS        = $clog2(TREE_DEPTH);
    localparam int SYM_BITS         = 8;
    localparam int BIT_IDX_BITS     = $clog2(SYM_BITS);
    localparam int MAX_RESULTS      = 32;
    localparam int CNT_BITS         = $clog2(MAX_RESULTS + 1);
    localparam int FLUSH_BYTES      = WORD_BITS / BYTE_BITS;
    localparam int IN_DEPTH         = 2;
    localparam int OUT_DEPTH        = 4;
    localparam int PROB_BITS_DEF    = 12;
    localparam int RATE_SHIFT_DEF   = 5;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef struct packed {
        logic                command;
        logic [SYM_BITS-1:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 last;
    } out_item_t;

    // head of the input queue as seen by the back end
    typedef struct packed {
        logic                valid;
        logic                is_flush;
        logic [SYM_BITS-1:0] symbol;
    } job_t;

    typedef struct packed {
        logic idle;
        logic pend_valid;
    } core_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_EMIT,
        ST_FLUSH,
        ST_FIN
    } core_state_t;

endpackage

`default_nettype wire

// File: design/bae_front.sv
// front end: input queue that classifies items into encode and flush jobs
`default_nettype none

module bae_front
    import bae_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output job_t          job,
    input  wire logic     job_take
);

    localparam int PTR_BITS = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int CNT_W    = $clog2(IN_DEPTH + 1);

    in_item_t               q_mem [IN_DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   do_wr;
    logic                   do_rd;
    in_item_t               head;

    assign full  = (cnt_reg == CNT_W'(IN_DEPTH));
    assign do_wr = push && !full;
    assign do_rd = job_take && (cnt_reg != '0);
    assign head  = q_mem[rd_ptr_reg];

    always_comb
    begin
        job.valid    = (cnt_reg != '0);
        job.is_flush = (head.command == CMD_FLUSH);
        job.symbol   = head.symbol;
    end

    always_comb
    begin
        wr_ptr_next = do_wr ? PTR_BITS'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? PTR_BITS'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (!do_wr && do_rd)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_mem[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

// File: design/bae_outq.sv
// output queue of coded bytes
`default_nettype none

module bae_outq
    import bae_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr,
    input  wire out_item_t wr_data,
    output logic           room,
    output logic           empty,
    input  wire logic      pop,
    output out_item_t      result
);

    localparam int PTR_BITS = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CNT_W    = $clog2(OUT_DEPTH + 1);

    out_item_t              q_mem [OUT_DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   do_wr;
    logic                   do_rd;

    assign room   = (cnt_reg != CNT_W'(OUT_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_wr  = wr && room;
    assign do_rd  = pop && !empty;
    assign result = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? PTR_BITS'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? PTR_BITS'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (!do_wr && do_rd)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: design/bae_core.sv
// back end: bit tree probabilities, interval update and byte output
`default_nettype none

module bae_core
    import bae_pkg::*;
#(
    parameter int PROB_BITS  = PROB_BITS_DEF,
    parameter int RATE_SHIFT = RATE_SHIFT_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire job_t   job,
    output logic        job_take,
    output logic        res_wr,
    output out_item_t   res_data,
    input  wire logic   res_room,
    output core_stat_t  stat
);

    localparam int PROD_BITS = WORD_BITS + PROB_BITS;
    localparam logic [PROB_BITS-1:0] PROB_HALF = {1'b1, {(PROB_BITS-1){1'b0}}};
    localparam logic [PROB_BITS:0]   PROB_SCALE = {1'b1, {PROB_BITS{1'b0}}};

    core_state_t            state_reg, state_next;
    logic [WORD_BITS-1:0]   low_reg, low_next;
    logic [WORD_BITS-1:0]   high_reg, high_next;
    logic [WORD_BITS-1:0]   prod_reg, prod_next;
    logic [SYM_BITS-1:0]    sym_reg, sym_next;
    logic [NODE_BITS-1:0]   node_reg, node_next;
    logic [BIT_IDX_BITS-1:0] bit_reg, bit_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [BYTE_BITS-1:0]   pend_byte_reg, pend_byte_next;

    logic [PROB_BITS-1:0]   prob_mem [TREE_DEPTH];
    logic [TREE_DEPTH-1:0]  vld_reg;
    logic [PROB_BITS-1:0]   rd_data_reg;
    logic                   rd_vld_reg;
    logic                   mem_re;
    logic [NODE_BITS-1:0]   rd_addr;
    logic                   mem_we;
    logic                   vld_clr;

    logic [PROB_BITS-1:0]   p_cur;
    logic [PROB_BITS:0]     p_up;
    logic [PROB_BITS-1:0]   p_new;
    logic                   bitv;
    logic [WORD_BITS-1:0]   span;
    logic [PROD_BITS-1:0]   prod_full;
    logic [WORD_BITS-1:0]   split;
    logic [BYTE_BITS-1:0]   low_top;
    logic                   top_eq;
    logic                   can_emit;
    logic                   emit;

    // an entry never written since reset or flush reads as one half
    assign p_cur = rd_vld_reg ? rd_data_reg : PROB_HALF;
    assign bitv  = sym_reg[bit_reg];
    assign p_up  = PROB_SCALE - {1'b0, p_cur};
    assign p_new = bitv ? PROB_BITS'(p_cur + PROB_BITS'(p_up >> RATE_SHIFT))
                        : PROB_BITS'(p_cur - (p_cur >> RATE_SHIFT));

    assign span      = high_reg - low_reg;
    assign prod_full = PROD_BITS'(span >> PROB_BITS) * PROD_BITS'(p_cur);
    assign split     = low_reg + prod_reg;

    assign low_top  = low_reg[WORD_BITS-1 -: BYTE_BITS];
    assign top_eq   = (low_top == high_reg[WORD_BITS-1 -: BYTE_BITS]);
    // one byte is held back so the final one of an item can be marked
    assign can_emit = !pend_valid_reg || res_room;

    assign stat.idle       = (state_reg == ST_IDLE);
    assign stat.pend_valid = pend_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        prod_next       = prod_reg;
        sym_next        = sym_reg;
        node_next       = node_reg;
        bit_next        = bit_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        job_take        = 1'b0;
        mem_re          = 1'b0;
        rd_addr         = node_reg;
        mem_we          = 1'b0;
        vld_clr         = 1'b0;
        emit            = 1'b0;
        res_wr          = 1'b0;
        res_data        = '{out_byte: pend_byte_reg, last: 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job.valid)
                begin
                    job_take = 1'b1;
                    cnt_next = '0;
                    if (job.is_flush)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        sym_next   = job.symbol;
                        node_next  = NODE_BITS'(1);
                        bit_next   = BIT_IDX_BITS'(SYM_BITS - 1);
                        mem_re     = 1'b1;
                        rd_addr    = NODE_BITS'(1);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = prod_full[WORD_BITS-1:0];
                mem_we     = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (bitv)
                begin
                    high_next = split;
                end
                else
                begin
                    low_next = split + 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (top_eq && (cnt_reg != CNT_BITS'(MAX_RESULTS)))
                begin
                    if (can_emit)
                    begin
                        emit      = 1'b1;
                        low_next  = {low_reg[WORD_BITS-BYTE_BITS-1:0], {BYTE_BITS{1'b0}}};
                        high_next = {high_reg[WORD_BITS-BYTE_BITS-1:0], {BYTE_BITS{1'b1}}};
                        cnt_next  = CNT_BITS'(cnt_reg + 1'b1);
                    end
                end
                else if (bit_reg != '0)
                begin
                    bit_next   = BIT_IDX_BITS'(bit_reg - 1'b1);
                    node_next  = {node_reg[NODE_BITS-2:0], bitv};
                    mem_re     = 1'b1;
                    rd_addr    = {node_reg[NODE_BITS-2:0], bitv};
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FLUSH:
            begin
                if (can_emit)
                begin
                    emit     = 1'b1;
                    low_next = {low_reg[WORD_BITS-BYTE_BITS-1:0], {BYTE_BITS{1'b0}}};
                    cnt_next = CNT_BITS'(cnt_reg + 1'b1);
                    if (cnt_reg == CNT_BITS'(FLUSH_BYTES - 1))
                    begin
                        // coder back to its reset state, last byte still held
                        low_next   = '0;
                        high_next  = '1;
                        vld_clr    = 1'b1;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (res_room)
                begin
                    res_wr          = 1'b1;
                    res_data.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            res_wr          = pend_valid_reg;
            pend_valid_next = 1'b1;
            pend_byte_next  = low_top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            low_reg        <= '0;
            high_reg       <= '1;
            pend_valid_reg <= 1'b0;
            vld_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            pend_valid_reg <= pend_valid_next;
            if (vld_clr)
            begin
                vld_reg <= '0;
            end
            else if (mem_we)
            begin
                vld_reg[node_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        sym_reg       <= sym_next;
        node_reg      <= node_next;
        bit_reg       <= bit_next;
        cnt_reg       <= cnt_next;
        pend_byte_reg <= pend_byte_next;
    end

    // probability store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prob_mem[node_reg] <= p_new;
        end
        if (mem_re)
        begin
            rd_data_reg <= prob_mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/binary_arith_encoder_bittree_unit.sv
// top level of the adaptive order-0 binary arithmetic encoder
//
//  channel   handshake          payload      direction
//  item      push / full        in_item_t    into the block (command, symbol)
//  result    pop / empty        out_item_t   out of the block (out_byte, last)
//
//  a symbol is started from idle, then each coded bit runs a multiply, an interval
//  update and a byte check with the next probability read; the byte check repeats
//  for each emitted byte, and a final step marks the last byte; the serial bit
//  loop through the shared multiplier sets the pace of all this
//  reset clears the interval, the queues and the valid bit of every tree node
//  a full output queue stalls only the back end; the input queue keeps taking
//  transfers until its two entries are taken
`default_nettype none

module binary_arith_encoder_bittree_unit
    import bae_pkg::*;
#(
    parameter int PROB_BITS  = PROB_BITS_DEF,
    parameter int RATE_SHIFT = RATE_SHIFT_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     result
);

    job_t        job;
    logic        job_take;
    logic        res_wr;
    out_item_t   res_data;
    logic        res_room;
    core_stat_t  stat;

    // front end: accepts transfers and tags flush versus encode
    bae_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .job      (job),
        .job_take (job_take)
    );

    // back end: codes one job at a time
    bae_core #(
        .PROB_BITS  (PROB_BITS),
        .RATE_SHIFT (RATE_SHIFT)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job),
        .job_take (job_take),
        .res_wr   (res_wr),
        .res_data (res_data),
        .res_room (res_room),
        .stat     (stat)
    );

    // coded bytes wait here for the consumer
    bae_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_wr),
        .wr_data (res_data),
        .room    (res_room),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // no byte may be written into a full output queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr |-> res_room)
        else $error("output queue overflow");

    // a new job only starts when the back end is idle
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> stat.idle)
        else $error("job taken while busy");

    // the held-back byte is always released before the back end goes idle
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        stat.idle |-> !stat.pend_valid)
        else $error("held byte left behind");

endmodule

`default_nettype wire
